// File: src/iterative_global_threshold_top_macros.svh
// Assertion helpers for the RTL of the threshold block.
`ifndef ITERATIVE_GLOBAL_THRESHOLD_TOP_MACROS_SVH
`define ITERATIVE_GLOBAL_THRESHOLD_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IGT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IGT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/igt_pkg.sv
// ----------------------------------------------------------------------------
// igt_pkg
// Types and constants of the iterative global threshold block.
// ----------------------------------------------------------------------------
package igt_pkg;

  localparam int BIN_COUNT = 256;

  // Configuration register indexes.
  localparam logic REG_TOLERANCE  = 1'b0;
  localparam logic REG_MAX_PASSES = 1'b1;

  localparam logic [7:0] TOLERANCE_RST  = 8'd3;
  localparam logic [7:0] MAX_PASSES_RST = 8'd64;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FLUSH,
    ST_SCAN,
    ST_PCHK,
    ST_PASS,
    ST_DIV,
    ST_UPD,
    ST_EMIT
  } igt_state_t;

endpackage

// File: src/iterative_global_threshold_top.sv
// ----------------------------------------------------------------------------
// iterative_global_threshold_top
// Usage: pixels stream in on in_* one word per cycle while in_tready is
// high (in_tdata = pixel, in_tlast marks the last pixel of an image). Each
// pixel is counted into a 256-bin histogram held in one synchronous RAM,
// with a read-modify-write and forwarding for repeated gray levels.
// After the last pixel the block scans the histogram once for the darkest
// and brightest occupied bins, then runs refinement passes. Each pass
// sweeps the RAM and then runs one shared 8-step divider twice; after the
// search one result word appears on out_* (threshold, converged, empty
// class). The histogram is then zeroed by a clearing sweep, during which
// in_tready is low. Reset starts the same clearing sweep.
// The result waits in an output register while the receiver stalls; the
// block goes on clearing and taking pixels, and only holds a new result
// until the earlier one has been taken.
// The tolerance and max_passes registers sit on the cfg_* APB port.
// ----------------------------------------------------------------------------
`include "iterative_global_threshold_top_macros.svh"

module iterative_global_threshold_top
  import igt_pkg::*;
#(
  parameter int MAX_PIXELS_LOG2 = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] pixel
  input  logic        in_tlast,     // last_pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // [7:0] threshold, [8] converged, [9] empty_class
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW = MAX_PIXELS_LOG2 + 1;  // bin count / pixel count
  localparam int SW = CW + 8;               // weighted sums, products

  igt_state_t state_r, state_nxt;

  logic [7:0] tol_r, maxp_r;

  // Histogram RAM
  logic [CW-1:0] mem [BIN_COUNT];
  logic [CW-1:0] mem_rdata_r;
  logic          mem_we;
  logic [7:0]    mem_waddr, mem_raddr;
  logic [CW-1:0] mem_wdata;

  // Pixel counting
  logic          acc_v_r, fwd_r;
  logic [7:0]    acc_addr_r;
  logic [CW-1:0] lastw_r;
  logic [CW-1:0] total_r;
  logic          in_acc, in_count;

  // Sweep pipeline
  logic [8:0]    sw_cnt_r;
  logic          rv1_r, v2_r, low2_r;
  logic [7:0]    ra1_r;
  logic [SW-1:0] prod_r;
  logic [CW-1:0] cnt2_r;
  logic          sweep_done;

  // Search state
  logic          found_r;
  logic [7:0]    lo_r, hi_r, t_r, pass_r;
  logic [CW-1:0] nlow_r, nhigh_r;
  logic [SW-1:0] slow_r, shigh_r;
  logic          conv_r, empty_r;
  logic [8:0]    mid_sum;

  // Shared divider
  logic [SW-1:0] rem_r, den_sh;
  logic [CW-1:0] den_r;
  logic [2:0]    k_r;
  logic [7:0]    q_r, q_lo_r, q_hi_r, q_fin;
  logic          div_hi_r, div_fit;

  logic [8:0]    next_sum;
  logic [7:0]    next_t, diff;
  logic          out_valid_r;
  logic [15:0]   out_data_r;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r  <= TOLERANCE_RST;
      maxp_r <= MAX_PASSES_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[2])
        REG_TOLERANCE:  tol_r  <= cfg_pwdata[7:0];
        REG_MAX_PASSES: maxp_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_TOLERANCE:  cfg_prdata = {24'd0, tol_r};
      REG_MAX_PASSES: cfg_prdata = {24'd0, maxp_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- handshakes ----------------
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign in_count   = in_acc && !total_r[CW-1];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sweep_done = sw_cnt_r[8] && !rv1_r && !v2_r;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sw_cnt_r[7:0] == 8'hFF) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_acc && in_tlast) state_nxt = ST_FLUSH;
      ST_FLUSH: state_nxt = ST_SCAN;
      ST_SCAN:  if (sweep_done) state_nxt = ST_PCHK;
      ST_PCHK:  state_nxt = (pass_r >= maxp_r) ? ST_EMIT : ST_PASS;
      ST_PASS: begin
        if (sweep_done) begin
          state_nxt = (nlow_r == '0 || nhigh_r == '0) ? ST_EMIT : ST_DIV;
        end
      end
      ST_DIV:   if (k_r == 3'd0 && div_hi_r) state_nxt = ST_UPD;
      ST_UPD:   state_nxt = (diff < tol_r) ? ST_EMIT : ST_PCHK;
      ST_EMIT:  if (!out_valid_r) state_nxt = ST_CLEAR;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // ---------------- RAM port control ----------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = acc_addr_r;
    mem_wdata = (fwd_r ? lastw_r : mem_rdata_r) + CW'(1);
    mem_raddr = in_tdata;
    unique case (state_r)
      ST_IDLE, ST_FLUSH: mem_we = acc_v_r;
      ST_SCAN, ST_PASS:  mem_raddr = sw_cnt_r[7:0];
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sw_cnt_r[7:0];
        mem_wdata = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= mem[mem_raddr];
  end

  // ---------------- datapath helpers ----------------
  assign mid_sum  = found_r ? ({1'b0, lo_r} + {1'b0, hi_r}) : 9'h1FE;
  assign den_sh   = {8'd0, den_r} << k_r;
  assign div_fit  = (rem_r >= den_sh);
  assign q_fin    = q_r | (div_fit ? (8'd1 << k_r) : 8'd0);
  assign next_sum = {1'b0, q_lo_r} + {1'b0, q_hi_r};
  assign next_t   = next_sum[8:1];
  assign diff     = (next_t > t_r) ? (next_t - t_r) : (t_r - next_t);

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sw_cnt_r    <= '0;
      acc_v_r     <= 1'b0;
      fwd_r       <= 1'b0;
      rv1_r       <= 1'b0;
      v2_r        <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      pass_r      <= '0;
      t_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      // Counting: a repeated gray level reads stale RAM data, so the value
      // written in that same cycle is forwarded.
      acc_v_r    <= in_count;
      acc_addr_r <= in_tdata;
      fwd_r      <= in_count && mem_we && (mem_waddr == in_tdata);
      if (mem_we) lastw_r <= mem_wdata;
      if (in_count) total_r <= total_r + CW'(1);

      // Sweep address and read pipeline
      rv1_r <= 1'b0;
      v2_r  <= 1'b0;
      if (state_r == ST_SCAN || state_r == ST_PASS) begin
        if (!sw_cnt_r[8]) sw_cnt_r <= sw_cnt_r + 9'd1;
        rv1_r <= !sw_cnt_r[8];
        ra1_r <= sw_cnt_r[7:0];
      end
      if (state_r == ST_CLEAR) sw_cnt_r <= sw_cnt_r + 9'd1;

      if (state_r == ST_SCAN && rv1_r && mem_rdata_r != '0) begin
        if (!found_r) lo_r <= ra1_r;
        hi_r    <= ra1_r;
        found_r <= 1'b1;
      end

      if (state_r == ST_PASS) begin
        v2_r   <= rv1_r;
        prod_r <= mem_rdata_r * ra1_r;
        cnt2_r <= mem_rdata_r;
        low2_r <= (ra1_r < t_r);
        if (v2_r) begin
          if (low2_r) begin
            nlow_r <= nlow_r + cnt2_r;
            slow_r <= slow_r + prod_r;
          end else begin
            nhigh_r <= nhigh_r + cnt2_r;
            shigh_r <= shigh_r + prod_r;
          end
        end
      end

      if (state_r == ST_DIV) begin
        if (div_fit) rem_r <= rem_r - den_sh;
        q_r <= q_fin;
        k_r <= k_r - 3'd1;
        if (k_r == 3'd0) begin
          if (!div_hi_r) begin
            q_lo_r   <= q_fin;
            div_hi_r <= 1'b1;
            rem_r    <= shigh_r;
            den_r    <= nhigh_r;
            q_r      <= '0;
          end else begin
            q_hi_r <= q_fin;
          end
        end
      end

      unique case (state_r)
        ST_FLUSH: begin
          sw_cnt_r <= '0;
          found_r  <= 1'b0;
        end
        ST_SCAN: begin
          if (sweep_done) begin
            t_r     <= mid_sum[8:1];
            pass_r  <= '0;
            conv_r  <= 1'b0;
            empty_r <= 1'b0;
          end
        end
        ST_PCHK: begin
          sw_cnt_r <= '0;
          nlow_r   <= '0;
          nhigh_r  <= '0;
          slow_r   <= '0;
          shigh_r  <= '0;
        end
        ST_PASS: begin
          if (sweep_done) begin
            pass_r   <= pass_r + 8'd1;
            empty_r  <= (nlow_r == '0 || nhigh_r == '0);
            rem_r    <= slow_r;
            den_r    <= nlow_r;
            k_r      <= 3'd7;
            q_r      <= '0;
            div_hi_r <= 1'b0;
          end
        end
        ST_UPD: begin
          t_r    <= next_t;
          conv_r <= (diff < tol_r);
        end
        ST_EMIT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {6'd0, empty_r, conv_r, t_r};
            sw_cnt_r    <= '0;
            total_r     <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- assertions ----------------
  `IGT_ASSERT_NOW(a_flags_exclusive, out_tvalid, !(out_tdata[8] && out_tdata[9]),
    "converged and empty_class both set")
  `IGT_ASSERT_NOW(a_no_write_in_search,
    (state_r == ST_SCAN || state_r == ST_PASS || state_r == ST_DIV), !mem_we,
    "histogram written during search")
  `IGT_ASSERT_NOW(a_class_means, state_r == ST_UPD, (q_lo_r < t_r) && (q_hi_r >= t_r),
    "class means on the wrong side of the threshold")
  `IGT_ASSERT_NEXT(a_pass_bound, state_r == ST_PCHK && pass_r >= maxp_r, state_r == ST_EMIT,
    "pass limit not honored")

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench of the iterative global threshold block
// Streams images into the block, predicts each threshold result from its
// own histogram model and compares every result word field by field.
// ----------------------------------------------------------------------------

class threshold_scoreboard;
  int unsigned hist[256];
  int unsigned npix;
  bit [7:0] tol = 8'd3;
  bit [7:0] maxp = 8'd64;
  bit [9:0] pending[$];
  int errors;

  function void clear_image();
    foreach (hist[i]) hist[i] = 0;
    npix = 0;
  endfunction

  // Runs the threshold search on the current histogram and queues the result.
  function void search();
    int lo, hi, k;
    int unsigned est, nxt, dif;
    int unsigned passes;
    longint unsigned nl, sl, nh, sh;
    bit conv, empty;
    lo = 0;
    hi = 255;
    conv = 0;
    empty = 0;
    while (lo < 255 && hist[lo] == 0) lo++;
    while (hi > 0 && hist[hi] == 0) hi--;
    if (hi < lo) hi = lo;
    est = (lo + hi) >> 1;
    passes = 0;
    while (passes < maxp) begin
      nl = 0; sl = 0; nh = 0; sh = 0;
      for (k = 0; k < 256; k++) begin
        if (k < est) begin
          nl += hist[k];
          sl += longint'(hist[k]) * k;
        end else begin
          nh += hist[k];
          sh += longint'(hist[k]) * k;
        end
      end
      passes++;
      if (nl == 0 || nh == 0) begin
        empty = 1;
        break;
      end
      nxt = ((sl / nl) + (sh / nh)) >> 1;
      dif = (nxt > est) ? nxt - est : est - nxt;
      est = nxt & 8'hff;
      if (dif < tol) begin
        conv = 1;
        break;
      end
    end
    pending.push_back({empty, conv, est[7:0]});
    clear_image();
  endfunction

  function void note_pixel(bit [7:0] px, bit last);
    if (npix < (1 << 20)) begin
      hist[px]++;
      npix++;
    end
    if (last) search();
  endfunction

  function void check_result(bit [15:0] word);
    bit [9:0] exp_w;
    if (pending.size() == 0) begin
      $error("result word with nothing expected: %h", word);
      errors++;
      return;
    end
    exp_w = pending.pop_front();
    if (word[7:0] !== exp_w[7:0]) begin
      $error("threshold: expected %0d, actual %0d", exp_w[7:0], word[7:0]);
      errors++;
    end
    if (word[8] !== exp_w[8]) begin
      $error("converged: expected %0d, actual %0d", exp_w[8], word[8]);
      errors++;
    end
    if (word[9] !== exp_w[9]) begin
      $error("empty_class: expected %0d, actual %0d", exp_w[9], word[9]);
      errors++;
    end
  endfunction
endclass

module tb
  import igt_pkg::*;
();

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [7:0]  in_tdata = 0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [15:0] out_tdata;
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [2:0]  cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  threshold_scoreboard thr_sb = new();
  bit hold_off = 0;
  bit stim_done = 0;

  always #2 clk = ~clk;

  iterative_global_threshold_top u_dut (.*);

  task automatic write_reg(input logic idx, input bit [7:0] val);
    @(posedge clk);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_paddr <= 3'(idx) << 2;
    cfg_pwdata <= {24'd0, val};
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    if (idx == REG_TOLERANCE) thr_sb.tol = val;
    else thr_sb.maxp = val;
  endtask

  // Sends one pixel word; the gap is drawn per word.
  task automatic send_pixel(input bit [7:0] px, input bit last, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= px;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    thr_sb.note_pixel(px, last);
  endtask

  // Stops offering words and waits for every expected result.
  task automatic drain();
    in_tvalid <= 0;
    while (thr_sb.pending.size() != 0) @(posedge clk);
    // the clearing sweep follows each result
    repeat (300) @(posedge clk);
  endtask

  task automatic send_image(input int n, input int mode, input bit gaps);
    int k;
    bit [7:0] a, b, px;
    a = $urandom_range(0, 255);
    b = $urandom_range(0, 255);
    for (k = 0; k < n; k++) begin
      case (mode)
        0: px = $urandom_range(0, 255);
        1: px = ($urandom_range(0, 1) ? a : b) ^ 8'($urandom_range(0, 7));
        default: px = a;
      endcase
      send_pixel(px, k == n - 1, gaps);
    end
  endtask

  // Receiver: random stalls, with one long hold-off when requested.
  always @(posedge clk) begin
    if (out_tvalid && out_tready) thr_sb.check_result(out_tdata);
  end

  initial begin
    int r;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 0;
        repeat (12000) @(posedge clk);
        hold_off = 0;
      end
      r = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) r = 0;
      if (r > 0) begin
        out_tready <= 0;
        repeat (r) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
    end
  end

  initial begin
    int sent;
    bit [7:0] t;
    bit held;
    held = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    // Directed: extremes and special cases at reset settings.
    send_pixel(8'd0, 0, 0);
    send_pixel(8'd255, 1, 0);          // two extreme levels
    send_pixel(8'd77, 1, 1);           // one-pixel image, empty class
    send_image(4, 2, 0);               // one-level image
    send_image(6, 1, 1);
    send_pixel(8'hAA, 0, 0);
    send_pixel(8'h55, 1, 0);
    drain();
    write_reg(REG_TOLERANCE, 8'd255);
    write_reg(REG_MAX_PASSES, 8'd1);
    send_image(5, 0, 1);
    drain();
    write_reg(REG_TOLERANCE, 8'd0);    // never converges
    write_reg(REG_MAX_PASSES, 8'd3);
    send_image(5, 0, 0);
    drain();
    write_reg(REG_MAX_PASSES, 8'd0);   // no pass runs
    send_image(3, 0, 0);
    drain();
    write_reg(REG_TOLERANCE, 8'd1);
    write_reg(REG_MAX_PASSES, 8'd255);
    send_image(6, 1, 0);
    drain();
    // Random phases with several settings.
    sent = 0;
    while (sent < 1000) begin
      t = $urandom_range(0, 4) == 0 ? 8'd255 : 8'($urandom_range(1, 8));
      write_reg(REG_TOLERANCE, t);
      write_reg(REG_MAX_PASSES, 8'($urandom_range(1, 12)));
      if (!held && sent >= 400) begin
        hold_off = 1;
        held = 1;
      end
      repeat (6) begin
        int n;
        n = $urandom_range(1, 30);
        send_image(n, $urandom_range(0, 5) == 0 ? 2 : $urandom_range(0, 1),
                   $urandom_range(0, 2) != 0);
        sent += n;
      end
      drain();
    end
    write_reg(REG_TOLERANCE, 8'd3);
    write_reg(REG_MAX_PASSES, 8'd64);
    send_image(40, 1, 0);
    drain();
    if (thr_sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("simulation failed");
    $finish;
  end
endmodule
